// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define CHBT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("chbt assertion failed");

// Next-cycle implication.
`define CHBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("chbt assertion failed");

`endif

// ===== rtl/chbt_pkg.sv =====
// Types and constants of the channel hash bucket table.
package chbt_pkg;

    localparam int HASH_W      = 8;
    localparam int IDX_W       = 6;
    localparam int NUM_BUCKETS = 256;
    localparam int KEY_CNT_W   = 6;
    localparam int CMD_Q_DEPTH = 2;

    localparam logic [HASH_W-1:0]    DEFAULT_NAME_HASH = 8'h0A;
    localparam logic [KEY_CNT_W-1:0] KEY_CNT_MAX       = 6'd63;
    localparam logic [KEY_CNT_W-1:0] KEY_LEN_SHORT     = 6'd16;
    localparam logic [KEY_CNT_W-1:0] KEY_LEN_LONG      = 6'd32;

    typedef enum logic [1:0] {
        OP_NAME   = 2'd0,
        OP_KEY    = 2'd1,
        OP_FINISH = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_KEY     = 2'd1,
        ST_TABLE_FULL  = 2'd2,
        ST_BUCKET_FULL = 2'd3
    } t_status;

    typedef enum logic {
        KIND_ADD    = 1'b0,
        KIND_LOOKUP = 1'b1
    } t_kind;

    // Command handed from the front end to the table engine.
    typedef struct packed {
        logic              is_lookup;
        logic              key_ok;
        logic [HASH_W-1:0] hash;
    } t_cmd;

endpackage

// ===== rtl/chbt_if.sv =====
// Valid/ready channels for input items and result words.
interface chbt_in_if import chbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [HASH_W-1:0] byte_value;

    modport source (output valid, operation, byte_value, input ready);
    modport sink (input valid, operation, byte_value, output ready);
endinterface

interface chbt_out_if import chbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [1:0]        status;
    logic [IDX_W-1:0]  entry_index;
    logic [HASH_W-1:0] hash_value;
    logic              found;
    logic              last_result;

    modport source (output valid, result_kind, status, entry_index, hash_value, found,
                    last_result, input ready);
    modport sink (input valid, result_kind, status, entry_index, hash_value, found,
                  last_result, output ready);
endinterface

// ===== rtl/chbt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module chbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/chbt_front.sv =====
// Front end: folds name/key bytes into the hash and queues finish/lookup commands.
module chbt_front import chbt_pkg::*; #(
    parameter int MAX_NAME_BYTES = 31
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chbt_in_if.sink    i_in,
    output logic       o_cmd_vld,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);

    localparam int NC_W = $clog2(MAX_NAME_BYTES + 1);
    localparam int QP_W = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
    localparam int QC_W = $clog2(CMD_Q_DEPTH + 1);

    logic [HASH_W-1:0]    r_acc;
    logic [NC_W-1:0]      r_name_cnt;
    logic [KEY_CNT_W-1:0] r_key_cnt;

    t_cmd            r_q [CMD_Q_DEPTH];
    logic [QP_W-1:0] r_wp, r_rp;
    logic [QC_W-1:0] r_cnt;

    logic w_accept, w_push;
    t_cmd w_push_cmd;

    assign i_in.ready = (r_cnt != QC_W'(CMD_Q_DEPTH));
    assign w_accept   = i_in.valid && i_in.ready;
    assign o_cmd_vld  = (r_cnt != '0);
    assign o_cmd      = r_q[r_rp];

    always_comb begin
        w_push     = 1'b0;
        w_push_cmd = '0;
        case (t_op'(i_in.operation))
            OP_FINISH: begin
                w_push               = w_accept;
                w_push_cmd.is_lookup = 1'b0;
                w_push_cmd.key_ok    = (r_key_cnt == '0) || (r_key_cnt == KEY_LEN_SHORT)
                                       || (r_key_cnt == KEY_LEN_LONG);
                w_push_cmd.hash      = (r_name_cnt == '0) ? (r_acc ^ DEFAULT_NAME_HASH)
                                                          : r_acc;
            end
            OP_LOOKUP: begin
                w_push               = w_accept;
                w_push_cmd.is_lookup = 1'b1;
                w_push_cmd.key_ok    = 1'b1;
                w_push_cmd.hash      = i_in.byte_value;
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_name_cnt <= '0;
            r_key_cnt  <= '0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
        end else begin
            if (w_accept) begin
                case (t_op'(i_in.operation))
                    OP_NAME: begin
                        // zero bytes and bytes past the limit do not count
                        if (i_in.byte_value != '0 &&
                            r_name_cnt < NC_W'(MAX_NAME_BYTES)) begin
                            r_acc      <= r_acc ^ i_in.byte_value;
                            r_name_cnt <= r_name_cnt + 1'b1;
                        end
                    end
                    OP_KEY: begin
                        r_acc <= r_acc ^ i_in.byte_value;
                        if (r_key_cnt != KEY_CNT_MAX) begin
                            r_key_cnt <= r_key_cnt + 1'b1;
                        end
                    end
                    OP_FINISH: begin
                        r_acc      <= '0;
                        r_name_cnt <= '0;
                        r_key_cnt  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_push) begin
                r_wp <= (r_wp == QP_W'(CMD_Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= (r_rp == QP_W'(CMD_Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_push_cmd;
        end
    end

endmodule

// ===== rtl/chbt_back.sv =====
// Table engine: bucket fill and slot memories, add commit, lookup readout.
module chbt_back import chbt_pkg::*; #(
    parameter int MAX_ENTRIES  = 64,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_vld,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    chbt_out_if.source o_out
);

    localparam int FILL_W   = $clog2(BUCKET_DEPTH + 1);
    localparam int ENTRY_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SLOT_N   = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int SLOT_AW  = $clog2(SLOT_N);
    localparam int BKT_AW   = $clog2(NUM_BUCKETS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_EMIT
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic               r_fill_known;
    logic [NUM_BUCKETS-1:0] r_bkt_vld;
    logic [FILL_W-1:0]  r_idx;
    logic [FILL_W-1:0]  r_n;
    logic [ENTRY_W-1:0] r_entry_count;

    logic              r_out_vld;
    t_kind             r_out_kind;
    t_status           r_out_status;
    logic [IDX_W-1:0]  r_out_index;
    logic [HASH_W-1:0] r_out_hash;
    logic              r_out_found;
    logic              r_out_last;

    logic [FILL_W-1:0]  w_fill_rdata, w_fill;
    logic [IDX_W-1:0]   w_slot_rdata;
    logic               w_out_free;
    logic               w_fill_re, w_fill_we, w_slot_re, w_slot_we;
    logic [BKT_AW-1:0]  w_fill_raddr;
    logic [SLOT_AW-1:0] w_slot_base, w_slot_raddr, w_slot_waddr;
    t_status            w_add_status;
    logic               w_last;

    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_fill     = r_fill_known ? w_fill_rdata : '0;
    assign w_slot_base = SLOT_AW'(r_cmd.hash) * SLOT_AW'(BUCKET_DEPTH);
    assign w_last     = ((r_idx + 1'b1) == r_n);

    always_comb begin
        if (!r_cmd.key_ok) begin
            w_add_status = ST_BAD_KEY;
        end else if (r_entry_count >= ENTRY_W'(MAX_ENTRIES)) begin
            w_add_status = ST_TABLE_FULL;
        end else if (w_fill >= FILL_W'(BUCKET_DEPTH)) begin
            w_add_status = ST_BUCKET_FULL;
        end else begin
            w_add_status = ST_OK;
        end
    end

    // memory controls
    always_comb begin
        o_cmd_pop    = 1'b0;
        w_fill_re    = 1'b0;
        w_fill_raddr = i_cmd.hash;
        w_fill_we    = 1'b0;
        w_slot_re    = 1'b0;
        w_slot_raddr = w_slot_base;
        w_slot_we    = 1'b0;
        w_slot_waddr = w_slot_base + SLOT_AW'(w_fill);
        case (r_state)
            S_IDLE: begin
                o_cmd_pop = i_cmd_vld;
                w_fill_re = i_cmd_vld;
            end
            S_FILL: begin
                if (w_out_free) begin
                    if (r_cmd.is_lookup) begin
                        w_slot_re = (w_fill != '0);
                    end else begin
                        w_fill_we = (w_add_status == ST_OK);
                        w_slot_we = (w_add_status == ST_OK);
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free && !w_last) begin
                    w_slot_re    = 1'b1;
                    w_slot_raddr = w_slot_base + SLOT_AW'(r_idx) + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_bkt_vld     <= '0;
            r_entry_count <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_vld) begin
                        r_cmd        <= i_cmd;
                        r_fill_known <= r_bkt_vld[i_cmd.hash];
                        r_state      <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (w_out_free) begin
                        r_out_hash <= r_cmd.hash;
                        if (r_cmd.is_lookup) begin
                            if (w_fill == '0) begin
                                r_out_vld    <= 1'b1;
                                r_out_kind   <= KIND_LOOKUP;
                                r_out_status <= ST_OK;
                                r_out_index  <= '0;
                                r_out_found  <= 1'b0;
                                r_out_last   <= 1'b1;
                                r_state      <= S_IDLE;
                            end else begin
                                r_idx   <= '0;
                                r_n     <= w_fill;
                                r_state <= S_EMIT;
                            end
                        end else begin
                            r_out_vld    <= 1'b1;
                            r_out_kind   <= KIND_ADD;
                            r_out_status <= w_add_status;
                            r_out_index  <= (w_add_status == ST_OK) ?
                                            IDX_W'(r_entry_count) : '0;
                            r_out_found  <= 1'b0;
                            r_out_last   <= 1'b1;
                            if (w_add_status == ST_OK) begin
                                r_bkt_vld[r_cmd.hash] <= 1'b1;
                                r_entry_count         <= r_entry_count + 1'b1;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_vld    <= 1'b1;
                        r_out_kind   <= KIND_LOOKUP;
                        r_out_status <= ST_OK;
                        r_out_index  <= w_slot_rdata;
                        r_out_hash   <= r_cmd.hash;
                        r_out_found  <= 1'b1;
                        r_out_last   <= w_last;
                        r_idx        <= r_idx + 1'b1;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    chbt_ram #(
        .WIDTH (FILL_W),
        .DEPTH (NUM_BUCKETS)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (w_fill_we),
        .i_waddr (r_cmd.hash),
        .i_wdata (w_fill + 1'b1),
        .i_re    (w_fill_re),
        .i_raddr (w_fill_raddr),
        .o_rdata (w_fill_rdata)
    );

    chbt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOT_N)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (IDX_W'(r_entry_count)),
        .i_re    (w_slot_re),
        .i_raddr (w_slot_raddr),
        .o_rdata (w_slot_rdata)
    );

    assign o_out.valid       = r_out_vld;
    assign o_out.result_kind = r_out_kind;
    assign o_out.status      = r_out_status;
    assign o_out.entry_index = r_out_index;
    assign o_out.hash_value  = r_out_hash;
    assign o_out.found       = r_out_found;
    assign o_out.last_result = r_out_last;

endmodule

// ===== rtl/channel_hash_bucket_table.sv =====
// Top level of the channel hash bucket table.
// Name and key bytes are XORed into an 8-bit channel hash as they arrive, one
// word per cycle while the command queue has room; a finish word checks the key
// length (0, 16 or 32 bytes), the table and the chosen bucket, and on success
// appends the next entry index to that bucket (one of 256), answering with one
// status word. A lookup word answers with every index in the bucket, oldest
// first, last one flagged, or one not-found word. A finish or lookup is queued
// (2 deep) for the table engine, which reads the bucket fill memory when it
// pops the command, then checks and updates the fill count or starts the slot
// reads, then emits each index read out of the slot memory. The result register
// holds a word until it is taken; meanwhile the engine may pop the next command
// and read its fill count, then stalls until the register frees up.
// The bucket fill counts are zeroed by per-bucket valid flops at reset, so no
// clearing pass is needed; slot entries are only ever read once written.
`include "assert_macros.svh"

module channel_hash_bucket_table import chbt_pkg::*; #(
    parameter int MAX_ENTRIES    = 64,
    parameter int BUCKET_DEPTH   = 8,
    parameter int MAX_NAME_BYTES = 31
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chbt_in_if.sink    i_in,
    chbt_out_if.source o_out
);

    logic w_cmd_vld;
    t_cmd w_cmd;
    logic w_cmd_pop;

    // front end: hash accumulation, command queue
    chbt_front #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_cmd_vld (w_cmd_vld),
        .o_cmd     (w_cmd),
        .i_cmd_pop (w_cmd_pop)
    );

    // table engine: buckets, adds, lookups, result register
    chbt_back #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (w_cmd_vld),
        .i_cmd     (w_cmd),
        .o_cmd_pop (w_cmd_pop),
        .o_out     (o_out)
    );

    // engine never pops an empty queue
    `CHBT_ASSERT_NOW(a_pop_needs_cmd, i_clk, i_rst_n, w_cmd_pop, w_cmd_vld)
    // add status word: single word, never marked found
    `CHBT_ASSERT_NOW(a_add_word, i_clk, i_rst_n,
        o_out.valid && (o_out.result_kind == KIND_ADD),
        o_out.last_result && !o_out.found)
    // failed add or not-found lookup carries index 0
    `CHBT_ASSERT_NOW(a_zero_index, i_clk, i_rst_n,
        o_out.valid && ((o_out.status != ST_OK) ||
                        ((o_out.result_kind == KIND_LOOKUP) && !o_out.found)),
        o_out.entry_index == '0)
    // lookup answers carry ok status
    `CHBT_ASSERT_NOW(a_lookup_ok, i_clk, i_rst_n,
        o_out.valid && (o_out.result_kind == KIND_LOOKUP), o_out.status == ST_OK)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the channel hash bucket table.
`timescale 1ns / 100ps

module tb_top import chbt_pkg::*; ();

    localparam int MAX_ENTRIES    = 64;
    localparam int BUCKET_DEPTH   = 8;
    localparam int MAX_NAME_BYTES = 31;

    localparam int RANDOM_WORDS = 45;      // rough size of the random part
    localparam int HOLD_AT      = 40;      // input words taken before the long result stall
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_FROM    = 110;     // no idling on either side in this word window
    localparam int CALM_TO      = 170;
    localparam int TAIL_CYCLES  = 30;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_CAP    = 40;
    localparam int FILL_ADDS    = 60;      // one-byte-name adds that run the table full

    // One input word waiting to be driven. hold_for_drain makes the sender
    // sit idle until every outstanding result has come back.
    typedef struct {
        t_op        op;
        logic [7:0] value;
        bit         hold_for_drain;
    } t_feed_word;

    // One result word, laid out as the output channel carries it.
    typedef struct {
        logic       kind;
        logic [1:0] status;
        logic [5:0] index;
        logic [7:0] hash;
        logic       found;
        logic       last;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    chbt_in_if  in_if ();
    chbt_out_if out_if ();

    channel_hash_bucket_table #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .BUCKET_DEPTH  (BUCKET_DEPTH),
        .MAX_NAME_BYTES(MAX_NAME_BYTES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block state
    // ------------------------------------------------------------------
    bit [7:0] hash_acc;
    bit [5:0] name_cnt;
    bit [5:0] key_cnt;
    bit [6:0] entry_cnt;
    bit [3:0] fill_count [256];
    bit [5:0] slot_index [256][BUCKET_DEPTH];

    t_feed_word feed_q[$];        // words still to be driven
    t_answer    due_results[$];   // results owed by the block, oldest first
    logic [7:0] aimed_hashes[$];  // hashes that generated adds should land in

    int  words_in;
    int  mismatches;
    int  cycle_count;
    int  hold_left;
    bit  hold_done;
    bit  in_fired;                // input word taken at the last rising edge
    t_feed_word cur;

    // Both sides run flat out inside this window.
    function automatic bit calm();
        return words_in >= CALM_FROM && words_in < CALM_TO;
    endfunction

    // Apply one accepted input word to the shadow state and queue the
    // result words it owes.
    task automatic hash_table_step(input t_op op, input logic [7:0] val);
        logic [7:0] h;
        t_status    st;
        logic [5:0] idx;
        int         n;
        case (op)
            OP_NAME: begin
                // zero bytes are skipped, and bytes past the name limit dropped
                if (val != 8'h00 && name_cnt < MAX_NAME_BYTES) begin
                    hash_acc ^= val;
                    name_cnt++;
                end
            end
            OP_KEY: begin
                hash_acc ^= val;
                if (key_cnt < KEY_CNT_MAX) key_cnt++;
            end
            OP_FINISH: begin
                h   = hash_acc;
                st  = ST_OK;
                idx = '0;
                if (name_cnt == 0) h ^= DEFAULT_NAME_HASH;
                // priority: key length, then table room, then bucket room
                if (key_cnt != 0 && key_cnt != KEY_LEN_SHORT && key_cnt != KEY_LEN_LONG) begin
                    st = ST_BAD_KEY;
                end else if (entry_cnt >= MAX_ENTRIES) begin
                    st = ST_TABLE_FULL;
                end else if (fill_count[h] >= BUCKET_DEPTH) begin
                    st = ST_BUCKET_FULL;
                end else begin
                    idx = entry_cnt[5:0];
                    slot_index[h][fill_count[h]] = idx;
                    fill_count[h]++;
                    entry_cnt++;
                end
                // accumulators clear on every finish, pass or fail
                hash_acc = '0;
                name_cnt = '0;
                key_cnt  = '0;
                due_results.push_back('{KIND_ADD, st, idx, h, 1'b0, 1'b1});
            end
            OP_LOOKUP: begin
                n = fill_count[val];
                if (n == 0) begin
                    due_results.push_back('{KIND_LOOKUP, ST_OK, 6'd0, val, 1'b0, 1'b1});
                end else begin
                    for (int i = 0; i < n; i++)
                        due_results.push_back('{KIND_LOOKUP, ST_OK, slot_index[val][i], val,
                                                1'b1, i == n - 1});
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(input t_op op, input logic [7:0] val, input bit drain = 1'b0);
        feed_q.push_back('{op, val, drain});
    endtask

    // Queue a full add: name bytes, key bytes, finish. Tracks roughly which
    // bucket it aims at so later lookups have something to find.
    task automatic queue_add(input int name_len, input int key_len);
        logic [7:0] b;
        logic [7:0] aim;
        int         named;
        aim   = '0;
        named = 0;
        for (int i = 0; i < name_len; i++) begin
            // half the bytes from a tiny alphabet so buckets collide
            b = ($urandom_range(99) < 50) ? 8'h41 + 8'($urandom_range(3))
                                          : 8'($urandom_range(255));
            if ($urandom_range(19) == 0) b = 8'h00;
            if (b != 8'h00 && named < MAX_NAME_BYTES) begin
                aim ^= b;
                named++;
            end
            push_word(OP_NAME, b);
        end
        for (int i = 0; i < key_len; i++) begin
            b = 8'($urandom_range(255));
            aim ^= b;
            push_word(OP_KEY, b);
        end
        if (named == 0) aim ^= DEFAULT_NAME_HASH;
        push_word(OP_FINISH, 8'($urandom_range(255)));
        aimed_hashes.push_back(aim);
    endtask

    task automatic queue_lookup();
        logic [7:0] h;
        if (aimed_hashes.size() != 0 && $urandom_range(99) < 70)
            h = aimed_hashes[$urandom_range(aimed_hashes.size() - 1)];
        else
            h = 8'($urandom_range(255));
        push_word(OP_LOOKUP, h);
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sampling at the rising edge: predict on every accepted input word,
    // then check any accepted result word against the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_answer seen;
        t_answer want;
        in_fired = i_rst_n && in_if.valid && in_if.ready;
        if (in_fired) begin
            hash_table_step(t_op'(in_if.operation), in_if.byte_value);
            words_in++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen = '{out_if.result_kind, out_if.status, out_if.entry_index,
                     out_if.hash_value, out_if.found, out_if.last_result};
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result word kind %0d hash %02h",
                                          seen.kind, seen.hash));
            end else begin
                want = due_results.pop_front();
                if (seen.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", seen.kind, want.kind));
                if (seen.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d (hash %02h)",
                                              seen.status, want.status, want.hash));
                if (seen.index !== want.index)
                    report_mismatch($sformatf("entry_index %0d, want %0d (hash %02h)",
                                              seen.index, want.index, want.hash));
                if (seen.hash !== want.hash)
                    report_mismatch($sformatf("hash_value %02h, want %02h",
                                              seen.hash, want.hash));
                if (seen.found !== want.found)
                    report_mismatch($sformatf("found %0d, want %0d (hash %02h)",
                                              seen.found, want.found, want.hash));
                if (seen.last !== want.last)
                    report_mismatch($sformatf("last_result %0d, want %0d (hash %02h)",
                                              seen.last, want.last, want.hash));
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: moves the input channel at the falling edge. A word stays up
    // until taken; the next one, or an idle slot, follows right after.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_if.valid || in_fired)) begin
            if (feed_q.size() != 0 &&
                !(feed_q[0].hold_for_drain && due_results.size() != 0) &&
                (calm() || $urandom_range(99) >= 38)) begin
                cur = feed_q.pop_front();
                in_if.valid      <= 1'b1;
                in_if.operation  <= cur.op;
                in_if.byte_value <= cur.value;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure: random stalls, plus one long hold-off once
    // enough words have gone in, so the command queue fills and the block
    // stops taking input while the sender keeps offering.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            out_if.ready  <= 1'b0;
        end else if (!hold_done && words_in >= HOLD_AT) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES - 1;
            out_if.ready  <= 1'b0;
        end else begin
            out_if.ready  <= calm() || $urandom_range(99) >= 38;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int stop_at;
        int r;
        int name_len;
        int key_len;

        in_if.valid      = 1'b0;
        in_if.operation  = OP_NAME;
        in_if.byte_value = 8'h00;
        out_if.ready     = 1'b0;
        i_rst_n          = 1'b0;
        words_in         = 0;
        mismatches       = 0;
        cycle_count      = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        in_fired         = 1'b0;
        hash_acc         = '0;
        name_cnt         = '0;
        key_cnt          = '0;
        entry_cnt        = '0;
        foreach (fill_count[i]) fill_count[i] = '0;

        // Directed: empty buckets at both ends of the hash range, the default
        // name, a name of only a zero byte, a bad key length, a lookup in the
        // middle of an add, and extreme byte values on every operation.
        push_word(OP_LOOKUP, 8'h00);
        push_word(OP_LOOKUP, 8'hFF);
        push_word(OP_FINISH, 8'h00);           // empty name -> default hash
        push_word(OP_NAME,   8'h00);           // skipped, name still empty
        push_word(OP_FINISH, 8'hFF);
        push_word(OP_NAME,   8'hFF);
        push_word(OP_KEY,    8'h00);           // one key byte -> bad length
        push_word(OP_FINISH, 8'h00);
        push_word(OP_NAME,   8'h55);
        push_word(OP_LOOKUP, DEFAULT_NAME_HASH); // add in flight, must survive
        push_word(OP_NAME,   8'hAA);
        push_word(OP_FINISH, 8'h00);
        push_word(OP_LOOKUP, 8'hFF);
        push_word(OP_NAME,   8'h80);
        push_word(OP_NAME,   8'h01);
        push_word(OP_KEY,    8'hFF);
        push_word(OP_KEY,    8'hFF);           // cancels, hash back to 0x81
        push_word(OP_FINISH, 8'h00);           // two key bytes -> bad length
        push_word(OP_LOOKUP, 8'h81);

        // Random: mostly well-formed adds, lookups aimed at filled buckets,
        // and some loose words that land in whatever add comes next.
        stop_at = feed_q.size() + RANDOM_WORDS;
        while (feed_q.size() < stop_at) begin
            r = $urandom_range(99);
            if (r < 50) begin
                r = $urandom_range(99);
                if (r < 15)      name_len = 0;
                else if (r < 85) name_len = $urandom_range(4, 1);
                else             name_len = $urandom_range(40, 32);   // past the limit
                r = $urandom_range(99);
                if (r < 65)      key_len = 0;
                else if (r < 77) key_len = 16;
                else if (r < 87) key_len = 32;
                else if (r < 95) key_len = $urandom_range(40, 1);
                else             key_len = $urandom_range(70, 60);    // count saturates
                queue_add(name_len, key_len);
            end else if (r < 80) begin
                queue_lookup();
            end else begin
                push_word(t_op'($urandom_range(3)), 8'($urandom_range(255)));
            end
        end

        // Sender pauses here until every owed result is back. Then the
        // default bucket is driven past full and read out whole.
        push_word(OP_FINISH, 8'($urandom_range(255)), 1'b1);
        repeat (BUCKET_DEPTH + 1) push_word(OP_FINISH, 8'($urandom_range(255)));
        push_word(OP_LOOKUP, DEFAULT_NAME_HASH);

        // Fill the table: one-byte names spread over distinct buckets.
        for (int k = 0; k < FILL_ADDS; k++) begin
            push_word(OP_NAME, 8'((k * 37) % 255 + 1));
            push_word(OP_FINISH, 8'($urandom_range(255)));
            aimed_hashes.push_back(8'((k * 37) % 255 + 1));
        end
        // Full table: a bad key still reports bad key first, a good one
        // reports table full even where the bucket is full too.
        push_word(OP_KEY, 8'($urandom_range(255)));
        push_word(OP_FINISH, 8'h00);
        push_word(OP_FINISH, 8'h00);
        push_word(OP_LOOKUP, DEFAULT_NAME_HASH);
        repeat (12) queue_lookup();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || in_if.valid) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        // let any stray word show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && due_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
